FILE: rtl/rcm_pkg.sv
package rcm_pkg;

  localparam int unsigned MaxRegionBases = 4096;
  localparam int unsigned AddrW          = $clog2(MaxRegionBases);
  localparam int unsigned LenW           = AddrW + 1;
  localparam int unsigned DepthBits      = 16;
  localparam int unsigned BitIdxW        = $clog2(DepthBits);
  localparam int unsigned CountW         = 32;
  localparam int unsigned CoordW         = 31;
  localparam int unsigned PosW           = 32;
  localparam int unsigned RlenW          = 16;
  localparam int unsigned InDataW        = 56;
  localparam int unsigned CfgIdxW        = 2;

  localparam logic [DepthBits-1:0] DepthMax = {DepthBits{1'b1}};
  localparam logic [CountW-1:0]    CountMax = {CountW{1'b1}};

  localparam logic [CfgIdxW-1:0] CfgMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStart = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEnd   = 2'd2;

  localparam logic CmdRecord = 1'b0;
  localparam logic CmdFinish = 1'b1;

  localparam logic ModeReads = 1'b0;
  localparam logic ModeBases = 1'b1;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRmwRd = 7'b0000010,
    StRmwWr = 7'b0000100,
    StScan  = 7'b0001000,
    StDrain = 7'b0010000,
    StEmit  = 7'b0100000,
    StClear = 7'b1000000
  } state_e;

endpackage

FILE: rtl/region_coverage_median_core.sv
// Region coverage core. Records and finish commands come in on the slave stream; a finish
// returns one result (read count, or median per-base depth, or region_error with coverage 0).
// A record that is filtered out, or any record in read mode, is taken without leaving idle. A
// base-mode record that is accepted then runs one read-modify-write of the depth memory per
// covered base. A finish in read mode or on a bad region posts its result, then runs the clear.
// A base-mode finish runs a bitwise median search over the memory: 16 passes, each a scan of
// the region's L bases (L = region length), twice for even L, then posts the result. Every
// finish ends with a clear of the whole depth memory, all 4096 entries, and the same clear
// runs after reset.
// The input is not ready during any of this; the result register frees the output side.
module region_coverage_median_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] read_position, [47:32] read_length, [48] is_duplicate, [49] failed_qc
  input  logic [rcm_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] command
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] coverage
  output logic [rcm_pkg::CountW-1:0]    m_axis_tdata,
  // [0] region_error
  output logic [0:0]                    m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rcm_pkg::CoordW-1:0]    cfg_data_i
);

  localparam int unsigned AW = rcm_pkg::AddrW;
  localparam int unsigned DW = rcm_pkg::DepthBits;

  rcm_pkg::state_e state_q, state_d;

  logic                      mode_q;
  logic [rcm_pkg::CoordW-1:0] start_q, end_q;
  logic [rcm_pkg::CountW-1:0] total_q, total_d;
  logic [AW-1:0]             cur_q, cur_d, last_q, last_d, scan_q, scan_d, clr_q, clr_d;
  logic [AW-1:0]             k_q, k_d;
  logic [rcm_pkg::LenW-1:0]  cnt_q, cnt_d;
  logic [DW-1:0]             ans_q, ans_d, lo_q, lo_d;
  logic [rcm_pkg::BitIdxW-1:0] bit_q, bit_d;
  logic                      pass_q, pass_d, rvld_q;
  logic [rcm_pkg::CountW-1:0] res_q, res_d;
  logic                      rerr_q, rerr_d;
  logic                      out_vld_q;
  logic [rcm_pkg::CountW-1:0] out_data_q;
  logic                      out_err_q;

  // region geometry
  logic [rcm_pkg::CoordW:0]  diff;
  logic                      region_ok;
  logic [AW-1:0]             len_m1;
  assign diff      = {1'b0, end_q} - {1'b0, start_q};
  assign region_ok = !diff[rcm_pkg::CoordW] &&
                     (diff[rcm_pkg::CoordW-1:0] <= rcm_pkg::CoordW'(rcm_pkg::MaxRegionBases - 1));
  assign len_m1    = diff[AW-1:0];

  // input decode
  logic [rcm_pkg::PosW-1:0]  pos;
  logic [rcm_pkg::RlenW-1:0] rlen;
  logic                      dup, qc, cmd, in_region, clip, in_fire;
  logic [rcm_pkg::PosW:0]    read_end;
  logic [AW-1:0]             last_pos;
  assign pos       = s_axis_tdata[31:0];
  assign rlen      = s_axis_tdata[47:32];
  assign dup       = s_axis_tdata[48];
  assign qc        = s_axis_tdata[49];
  assign cmd       = s_axis_tuser[0];
  assign in_region = !pos[rcm_pkg::PosW-1] && (pos[rcm_pkg::CoordW-1:0] >= start_q) &&
                     (pos[rcm_pkg::CoordW-1:0] <= end_q);
  assign read_end  = {1'b0, pos} + {{(rcm_pkg::PosW+1-rcm_pkg::RlenW){1'b0}}, rlen}
                     - (rcm_pkg::PosW+1)'(1);
  assign clip      = read_end > {2'b00, end_q};
  assign last_pos  = clip ? end_q[AW-1:0] : read_end[AW-1:0];

  assign s_axis_tready = (state_q == rcm_pkg::StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // depth memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  rcm_ram #(
    .Width (DW),
    .Depth (rcm_pkg::MaxRegionBases)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared compare unit of the median search
  logic [DW-1:0]            cand, ans_n;
  logic                     less;
  logic [rcm_pkg::LenW-1:0] cnt_fin;
  logic [DW:0]              mid_sum;
  assign cand    = ans_q | (DW'(1) << bit_q);
  assign less    = ram_rdata < cand;
  assign cnt_fin = cnt_q + rcm_pkg::LenW'(less);
  assign ans_n   = (cnt_fin <= {1'b0, k_q}) ? cand : ans_q;
  assign mid_sum = {1'b0, lo_q} + {1'b0, ans_n};

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    cur_d     = cur_q;
    last_d    = last_q;
    scan_d    = scan_q;
    clr_d     = clr_q;
    k_d       = k_q;
    cnt_d     = cnt_q;
    ans_d     = ans_q;
    lo_d      = lo_q;
    bit_d     = bit_q;
    pass_d    = pass_q;
    res_d     = res_q;
    rerr_d    = rerr_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = '0;
    ram_raddr = cur_q;
    case (state_q)
      rcm_pkg::StIdle: begin
        if (in_fire) begin
          if (cmd == rcm_pkg::CmdRecord) begin
            if (!dup && !qc && in_region) begin
              if (mode_q == rcm_pkg::ModeReads) begin
                if (total_q != rcm_pkg::CountMax) total_d = total_q + rcm_pkg::CountW'(1);
              end else if (region_ok && (rlen != '0)) begin
                cur_d   = pos[AW-1:0] - start_q[AW-1:0];
                last_d  = last_pos - start_q[AW-1:0];
                state_d = rcm_pkg::StRmwRd;
              end
            end
          end else if (!region_ok) begin
            res_d   = '0;
            rerr_d  = 1'b1;
            state_d = rcm_pkg::StEmit;
          end else if (mode_q == rcm_pkg::ModeReads) begin
            res_d   = total_q;
            rerr_d  = 1'b0;
            state_d = rcm_pkg::StEmit;
          end else begin
            k_d     = {1'b0, len_m1[AW-1:1]};
            pass_d  = 1'b0;
            ans_d   = '0;
            bit_d   = rcm_pkg::BitIdxW'(DW - 1);
            scan_d  = '0;
            cnt_d   = '0;
            rerr_d  = 1'b0;
            state_d = rcm_pkg::StScan;
          end
        end
      end
      rcm_pkg::StRmwRd: begin
        state_d = rcm_pkg::StRmwWr;
      end
      rcm_pkg::StRmwWr: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata == rcm_pkg::DepthMax) ? ram_rdata : ram_rdata + DW'(1);
        if (cur_q == last_q) begin
          state_d = rcm_pkg::StIdle;
        end else begin
          cur_d   = cur_q + AW'(1);
          state_d = rcm_pkg::StRmwRd;
        end
      end
      rcm_pkg::StScan: begin
        ram_raddr = scan_q;
        if (rvld_q && less) cnt_d = cnt_q + rcm_pkg::LenW'(1);
        if (scan_q == len_m1) begin
          state_d = rcm_pkg::StDrain;
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end
      rcm_pkg::StDrain: begin
        scan_d = '0;
        cnt_d  = '0;
        if (bit_q == '0) begin
          if (!pass_q && len_m1[0]) begin
            // even length: hold the lower middle element and search for the upper one
            lo_d    = ans_n;
            pass_d  = 1'b1;
            k_d     = k_q + AW'(1);
            ans_d   = '0;
            bit_d   = rcm_pkg::BitIdxW'(DW - 1);
            state_d = rcm_pkg::StScan;
          end else begin
            res_d   = pass_q ? rcm_pkg::CountW'(mid_sum[DW:1]) : rcm_pkg::CountW'(ans_n);
            state_d = rcm_pkg::StEmit;
          end
        end else begin
          ans_d   = ans_n;
          bit_d   = bit_q - rcm_pkg::BitIdxW'(1);
          state_d = rcm_pkg::StScan;
        end
      end
      rcm_pkg::StEmit: begin
        if (!out_vld_q || m_axis_tready) begin
          total_d = '0;
          clr_d   = '0;
          state_d = rcm_pkg::StClear;
        end
      end
      rcm_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == {AW{1'b1}}) begin
          state_d = rcm_pkg::StIdle;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      default: begin
        state_d = rcm_pkg::StIdle;
      end
    endcase
  end

  logic out_load;
  assign out_load = (state_q == rcm_pkg::StEmit) && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rcm_pkg::StClear;
      clr_q     <= '0;
      total_q   <= '0;
      mode_q    <= 1'b0;
      start_q   <= '0;
      end_q     <= '0;
      out_vld_q <= 1'b0;
      rvld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      total_q <= total_d;
      rvld_q  <= (state_q == rcm_pkg::StScan);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rcm_pkg::CfgMode:  mode_q  <= cfg_data_i[0];
          rcm_pkg::CfgStart: start_q <= cfg_data_i;
          rcm_pkg::CfgEnd:   end_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    last_q <= last_d;
    scan_q <= scan_d;
    k_q    <= k_d;
    cnt_q  <= cnt_d;
    ans_q  <= ans_d;
    lo_q   <= lo_d;
    bit_q  <= bit_d;
    pass_q <= pass_d;
    res_q  <= res_d;
    rerr_q <= rerr_d;
    if (out_load) begin
      out_data_q <= res_q;
      out_err_q  <= rerr_q;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_err_q;

endmodule

FILE: rtl/rcm_ram.sv
module rcm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/rcm_checker.sv
module rcm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [rcm_pkg::InDataW-1:0]   s_axis_tdata,
  input logic [0:0]                    s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rcm_pkg::CountW-1:0]    m_axis_tdata,
  input logic [0:0]                    m_axis_tuser,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [rcm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input logic [rcm_pkg::CoordW-1:0]    cfg_data_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a bad region always reports zero coverage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("region error with nonzero coverage");

  // a record never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == rcm_pkg::CmdRecord) &&
    !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result after a record");

  // a finish transfer blocks the input while it is worked off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == rcm_pkg::CmdFinish)
    |=> !s_axis_tready)
    else $error("input ready right after finish");

endmodule

bind region_coverage_median_core rcm_checker u_rcm_checker (.*);
